// File: hw/rtl/pls_pkg.sv
// Shared types and codes for the positional list store.
package pls_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned KindW = 3;
  localparam int unsigned PosW  = 5;
  localparam int unsigned LenW  = 5;
  localparam int unsigned StatW = 2;

  typedef enum logic [KindW-1:0] {
    KIND_INS_FIRST = 3'd0,
    KIND_INS_LAST  = 3'd1,
    KIND_INS_AT    = 3'd2,
    KIND_DEL_FIRST = 3'd3,
    KIND_DEL_LAST  = 3'd4,
    KIND_DEL_AT    = 3'd5,
    KIND_DUMP      = 3'd6,
    KIND_NOP       = 3'd7
  } kind_t;

  typedef enum logic [StatW-1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_t;

  // What every cell of the chain does in a cycle.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } ctrl_state_t;

endpackage

// File: hw/rtl/pls_cell.sv
// One word cell of the shifting list chain.
module pls_cell #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned INDEX = 0
) (
  input  logic                              clk,
  input  pls_pkg::cell_op_t                 op,
  input  logic [IDX_W-1:0]                  idx,
  input  logic [IDX_W-1:0]                  last_idx,
  input  logic signed [pls_pkg::WordW-1:0]  value,
  input  logic signed [pls_pkg::WordW-1:0]  prev_word,
  input  logic signed [pls_pkg::WordW-1:0]  next_word,
  input  logic signed [pls_pkg::WordW-1:0]  head_word,
  output logic signed [pls_pkg::WordW-1:0]  word
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic signed [pls_pkg::WordW-1:0] word_next;

  always_comb begin
    word_next = word;
    unique case (op)
      pls_pkg::OP_INSERT: begin
        if (MyIdx > idx) begin
          word_next = prev_word;
        end else if (MyIdx == idx) begin
          word_next = value;
        end
      end
      pls_pkg::OP_REMOVE: begin
        if (MyIdx >= idx) begin
          word_next = next_word;
        end
      end
      // The tail takes the head back so the list is whole after a full turn.
      pls_pkg::OP_ROTATE: begin
        if (MyIdx == last_idx) begin
          word_next = head_word;
        end else begin
          word_next = next_word;
        end
      end
      pls_pkg::OP_HOLD: word_next = word;
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// File: hw/rtl/pls_ctrl.sv
// Operation decode, occupancy count, dump sequencer and result register.
module pls_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4,
  parameter int unsigned OCC_W = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [pls_pkg::KindW-1:0]         kind,
  input  logic [pls_pkg::PosW-1:0]          position,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [pls_pkg::WordW-1:0]  entry,
  output logic [pls_pkg::LenW-1:0]          length,
  output logic [pls_pkg::StatW-1:0]         status,
  output logic                              last,
  input  logic signed [pls_pkg::WordW-1:0]  head_word,
  output pls_pkg::cell_op_t                 cell_op,
  output logic [IDX_W-1:0]                  cell_idx,
  output logic [IDX_W-1:0]                  cell_last_idx
);

  localparam int unsigned CMP_W = ((OCC_W > pls_pkg::PosW) ? OCC_W : pls_pkg::PosW) + 1;
  localparam logic [OCC_W-1:0] Full = OCC_W'(DEPTH);

  pls_pkg::ctrl_state_t state, state_next;
  logic [OCC_W-1:0] occ, occ_next;
  logic [OCC_W-1:0] remain, remain_next;

  logic slot_free;
  logic accept;
  logic load;
  logic signed [pls_pkg::WordW-1:0] entry_next;
  logic [OCC_W-1:0] len_next;
  pls_pkg::status_t status_next;
  logic last_next;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] occ_ext;
  logic [CMP_W-1:0] pos_m1;
  logic [OCC_W-1:0] occ_m1;
  logic pos_nonzero;
  pls_pkg::kind_t kind_op;

  assign slot_free   = !result_valid || !result_stall;
  assign kind_op     = pls_pkg::kind_t'(kind);
  assign pos_ext     = CMP_W'(position);
  assign occ_ext     = CMP_W'(occ);
  assign pos_m1      = pos_ext - CMP_W'(1);
  assign occ_m1      = occ - OCC_W'(1);
  assign pos_nonzero = (position != '0);
  assign accept      = item_valid && !item_stall;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pls_pkg::ST_IDLE: begin
        // A one-word dump is finished with its first result.
        if (accept && kind_op == pls_pkg::KIND_DUMP && occ > OCC_W'(1)) begin
          state_next = pls_pkg::ST_DUMP;
        end
      end
      pls_pkg::ST_DUMP: begin
        if (slot_free && remain == OCC_W'(1)) begin
          state_next = pls_pkg::ST_IDLE;
        end
      end
      default: state_next = pls_pkg::ST_IDLE;
    endcase
  end

  // Outputs, cell commands and result contents.
  always_comb begin
    item_stall    = 1'b1;
    load          = 1'b0;
    entry_next    = '0;
    len_next      = occ;
    status_next   = pls_pkg::STAT_OK;
    last_next     = 1'b1;
    occ_next      = occ;
    remain_next   = remain;
    cell_op       = pls_pkg::OP_HOLD;
    cell_idx      = '0;
    cell_last_idx = IDX_W'(occ_m1);
    unique case (state)
      pls_pkg::ST_IDLE: begin
        item_stall = !slot_free;
        if (accept) begin
          load = 1'b1;
          unique case (kind_op)
            pls_pkg::KIND_INS_FIRST, pls_pkg::KIND_INS_LAST, pls_pkg::KIND_INS_AT: begin
              if (kind_op == pls_pkg::KIND_INS_AT &&
                  (!pos_nonzero || pos_ext > occ_ext + CMP_W'(1))) begin
                status_next = pls_pkg::STAT_BADPOS;
              end else if (occ == Full) begin
                status_next = pls_pkg::STAT_FULL;
              end else begin
                cell_op  = pls_pkg::OP_INSERT;
                occ_next = occ + OCC_W'(1);
                len_next = occ_next;
                if (kind_op == pls_pkg::KIND_INS_LAST) begin
                  cell_idx = IDX_W'(occ);
                end else if (kind_op == pls_pkg::KIND_INS_AT) begin
                  cell_idx = IDX_W'(pos_m1);
                end
              end
            end
            pls_pkg::KIND_DEL_FIRST, pls_pkg::KIND_DEL_LAST, pls_pkg::KIND_DEL_AT: begin
              if (occ == '0) begin
                status_next = pls_pkg::STAT_EMPTY;
              end else if (kind_op == pls_pkg::KIND_DEL_AT &&
                           (!pos_nonzero || pos_ext > occ_ext)) begin
                status_next = pls_pkg::STAT_BADPOS;
              end else begin
                cell_op  = pls_pkg::OP_REMOVE;
                occ_next = occ_m1;
                len_next = occ_next;
                if (kind_op == pls_pkg::KIND_DEL_LAST) begin
                  cell_idx = IDX_W'(occ_m1);
                end else if (kind_op == pls_pkg::KIND_DEL_AT) begin
                  cell_idx = IDX_W'(pos_m1);
                end
              end
            end
            pls_pkg::KIND_DUMP: begin
              if (occ == '0) begin
                status_next = pls_pkg::STAT_EMPTY;
              end else begin
                // First word goes out now; the rest stream from the chain.
                entry_next  = head_word;
                last_next   = (occ == OCC_W'(1));
                cell_op     = pls_pkg::OP_ROTATE;
                remain_next = occ_m1;
              end
            end
            default: ;
          endcase
        end
      end
      pls_pkg::ST_DUMP: begin
        if (slot_free) begin
          load        = 1'b1;
          entry_next  = head_word;
          last_next   = (remain == OCC_W'(1));
          cell_op     = pls_pkg::OP_ROTATE;
          remain_next = remain - OCC_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pls_pkg::ST_IDLE;
      occ          <= '0;
      remain       <= '0;
      result_valid <= 1'b0;
    end else begin
      state  <= state_next;
      occ    <= occ_next;
      remain <= remain_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry  <= entry_next;
      length <= pls_pkg::LenW'(len_next);
      status <= status_next;
      last   <= last_next;
    end
  end

endmodule

// File: hw/rtl/positional_list_store_core.sv
// Top level of the positional list store: controller and word cell chain.
// Holds an ordered list of up to DEPTH signed words in a chain of cells, first word in
// cell 0. On an insert or delete every cell picks
// its own word, its left or right neighbor's word or the new value in the same clock, so
// a positional insert or delete moves the whole tail at once. A dump of n words gives n
// results, one per cycle while the result side takes them; the chain rotates one place
// per result and is back in order after the last one, and no item is accepted during a
// dump. A new item is accepted whenever the result register is empty or being taken.
// The length field carries the low five bits of the occupancy.
module positional_list_store_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [pls_pkg::KindW-1:0]         kind,
  input  logic signed [pls_pkg::WordW-1:0]  value,
  input  logic [pls_pkg::PosW-1:0]          position,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [pls_pkg::WordW-1:0]  entry,
  output logic [pls_pkg::LenW-1:0]          length,
  output logic [pls_pkg::StatW-1:0]         status,
  output logic                              last
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);

  pls_pkg::cell_op_t cell_op;
  logic [IDX_W-1:0] cell_idx;
  logic [IDX_W-1:0] cell_last_idx;
  logic signed [pls_pkg::WordW-1:0] words [DEPTH];

  pls_ctrl #(
    .DEPTH(DEPTH),
    .IDX_W(IDX_W),
    .OCC_W(OCC_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .position     (position),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .entry        (entry),
    .length       (length),
    .status       (status),
    .last         (last),
    .head_word    (words[0]),
    .cell_op      (cell_op),
    .cell_idx     (cell_idx),
    .cell_last_idx(cell_last_idx)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [pls_pkg::WordW-1:0] prev_w;
    logic signed [pls_pkg::WordW-1:0] next_w;

    if (i == 0) begin : g_first
      assign prev_w = words[i];
    end else begin : g_mid_prev
      assign prev_w = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_w = words[i];
    end else begin : g_mid_next
      assign next_w = words[i+1];
    end

    pls_cell #(
      .IDX_W(IDX_W),
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .op       (cell_op),
      .idx      (cell_idx),
      .last_idx (cell_last_idx),
      .value    (value),
      .prev_word(prev_w),
      .next_word(next_w),
      .head_word(words[0]),
      .word     (words[i])
    );
  end

endmodule

// File: hw/rtl/pls_checker.sv
// Port-level checks of the positional list store, bound to the top level.
module pls_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              item_valid,
  input logic                              item_stall,
  input logic [pls_pkg::KindW-1:0]         kind,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic signed [pls_pkg::WordW-1:0]  entry,
  input logic [pls_pkg::LenW-1:0]          length,
  input logic [pls_pkg::StatW-1:0]         status,
  input logic                              last
);

  localparam logic [pls_pkg::LenW-1:0] FullLen = pls_pkg::LenW'(DEPTH);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(entry) && $stable(last)
                                     && $stable(status) && $stable(length))
    else $error("stalled result changed");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && kind != pls_pkg::KIND_DUMP |=> result_valid && last)
    else $error("non-dump item gave no final result in the next cycle");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == pls_pkg::STAT_FULL |-> length == FullLen && last)
    else $error("full status with wrong length");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == pls_pkg::STAT_EMPTY |-> length == '0 && entry == '0 && last)
    else $error("empty status with nonzero length or entry");

endmodule

bind positional_list_store_core pls_checker #(.DEPTH(DEPTH)) u_pls_checker (.*);

// File: tb/positional_list_store_checker.sv
// Watches both channels of the list store, predicts every result and compares.
module positional_list_store_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  input  logic                              item_stall,
  input  logic [pls_pkg::KindW-1:0]         kind,
  input  logic signed [pls_pkg::WordW-1:0]  value,
  input  logic [pls_pkg::PosW-1:0]          position,
  input  logic                              result_valid,
  input  logic                              result_stall,
  input  logic signed [pls_pkg::WordW-1:0]  entry,
  input  logic [pls_pkg::LenW-1:0]          length,
  input  logic [pls_pkg::StatW-1:0]         status,
  input  logic                              last,
  output int                                fail_count,
  output int                                pending,
  output int                                stored_words,
  output int                                compared
);

  typedef struct packed {
    logic signed [pls_pkg::WordW-1:0] entry;
    logic [pls_pkg::LenW-1:0]         length;
    pls_pkg::status_t                 status;
    logic                             last;
  } outcome_t;

  logic signed [pls_pkg::WordW-1:0] words[$];
  outcome_t                         outcomes[$];
  outcome_t                         want;

  function automatic outcome_t status_outcome(pls_pkg::status_t st);
    outcome_t o;
    o.entry  = '0;
    o.length = pls_pkg::LenW'(words.size());
    o.status = st;
    o.last   = 1'b1;
    return o;
  endfunction

  // Update the list copy and queue the results that one item causes.
  task automatic apply_item(pls_pkg::kind_t op, logic signed [pls_pkg::WordW-1:0] word,
                            logic [pls_pkg::PosW-1:0] pos);
    int unsigned      n;
    int               at;
    pls_pkg::status_t st;
    outcome_t         o;
    n  = words.size();
    at = int'(pos) - 1;
    st = pls_pkg::STAT_OK;
    case (op)
      pls_pkg::KIND_INS_FIRST, pls_pkg::KIND_INS_LAST, pls_pkg::KIND_INS_AT: begin
        // position check wins over the full check
        if (op == pls_pkg::KIND_INS_AT && (pos < 1 || pos > n + 1)) st = pls_pkg::STAT_BADPOS;
        else if (n >= DEPTH) st = pls_pkg::STAT_FULL;
        else if (op == pls_pkg::KIND_INS_FIRST) words.push_front(word);
        else if (op == pls_pkg::KIND_INS_LAST) words.push_back(word);
        else words.insert(at, word);
      end
      pls_pkg::KIND_DEL_FIRST, pls_pkg::KIND_DEL_LAST, pls_pkg::KIND_DEL_AT: begin
        if (n == 0) st = pls_pkg::STAT_EMPTY;
        else if (op == pls_pkg::KIND_DEL_AT && (pos < 1 || pos > n)) st = pls_pkg::STAT_BADPOS;
        else if (op == pls_pkg::KIND_DEL_FIRST) void'(words.pop_front());
        else if (op == pls_pkg::KIND_DEL_LAST) void'(words.pop_back());
        else words.delete(at);
      end
      pls_pkg::KIND_DUMP: begin
        if (n == 0) begin
          outcomes.push_back(status_outcome(pls_pkg::STAT_EMPTY));
        end else begin
          for (int i = 0; i < n; i++) begin
            o.entry  = words[i];
            o.length = pls_pkg::LenW'(n);
            o.status = pls_pkg::STAT_OK;
            o.last   = (i == n - 1);
            outcomes.push_back(o);
          end
        end
        return;
      end
      default: ;
    endcase
    outcomes.push_back(status_outcome(st));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      words.delete();
      outcomes.delete();
    end else begin
      if (item_valid && !item_stall) apply_item(pls_pkg::kind_t'(kind), value, position);
      if (result_valid && !result_stall) begin
        compared++;
        if (outcomes.size() == 0) begin
          $error("unexpected result: entry %0d length %0d status %0d last %0d",
                 entry, length, status, last);
          fail_count++;
        end else begin
          want = outcomes.pop_front();
          if (entry !== want.entry) begin
            $error("entry: expected %0d, got %0d", want.entry, entry);
            fail_count++;
          end
          if (length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, length);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            fail_count++;
          end
        end
      end
    end
    pending      = outcomes.size();
    stored_words = words.size();
  end

endmodule

// File: tb/positional_list_store_core_test.sv
// Stimulus and verdict for the positional list store core.
module positional_list_store_core_test;

  localparam int unsigned Depth = 16;
  localparam int CycleLimit = 200000;
  localparam int TailCycles = 40;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             item_valid;
  logic                             item_stall;
  logic [pls_pkg::KindW-1:0]        kind;
  logic signed [pls_pkg::WordW-1:0] value;
  logic [pls_pkg::PosW-1:0]         position;
  logic                             result_valid;
  logic                             result_stall;
  logic signed [pls_pkg::WordW-1:0] entry;
  logic [pls_pkg::LenW-1:0]         length;
  logic [pls_pkg::StatW-1:0]        status;
  logic                             last;

  int fail_count;
  int pending;
  int stored_words;
  int compared;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int dumps_sent = 0;

  positional_list_store_core #(.DEPTH(Depth)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .kind(kind), .value(value), .position(position),
    .result_valid(result_valid), .result_stall(result_stall),
    .entry(entry), .length(length), .status(status), .last(last)
  );

  positional_list_store_checker #(.DEPTH(Depth)) scoreboard (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .kind(kind), .value(value), .position(position),
    .result_valid(result_valid), .result_stall(result_stall),
    .entry(entry), .length(length), .status(status), .last(last),
    .fail_count(fail_count), .pending(pending),
    .stored_words(stored_words), .compared(compared)
  );

  always #5 clk = ~clk;

  always @(negedge clk) result_stall <= ($urandom_range(0, 99) < recv_idle_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Call at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(pls_pkg::kind_t op, logic signed [pls_pkg::WordW-1:0] word,
                           logic [pls_pkg::PosW-1:0] pos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    kind       <= op;
    value      <= word;
    position   <= pos;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (op == pls_pkg::KIND_DUMP) dumps_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [pls_pkg::WordW-1:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // bias 0 leans to filling the store, 1 to draining it, 2 is balanced
  task automatic send_random(int bias);
    int                       r;
    int                       ins_pct;
    int                       del_pct;
    pls_pkg::kind_t           op;
    logic [pls_pkg::PosW-1:0] pos;
    ins_pct = (bias == 0) ? 78 : (bias == 1) ? 14 : 42;
    del_pct = (bias == 0) ? 8 : (bias == 1) ? 72 : 42;
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      op = pls_pkg::kind_t'($urandom_range(pls_pkg::KIND_INS_FIRST, pls_pkg::KIND_INS_AT));
    end else if (r < ins_pct + del_pct) begin
      op = pls_pkg::kind_t'($urandom_range(pls_pkg::KIND_DEL_FIRST, pls_pkg::KIND_DEL_AT));
    end else if (r < 97) begin
      op = pls_pkg::KIND_DUMP;
    end else begin
      op = pls_pkg::KIND_NOP;
    end
    pos = pls_pkg::PosW'($urandom_range(0, 31));
    if ($urandom_range(0, 9) < 8) begin
      if (op == pls_pkg::KIND_INS_AT) begin
        pos = pls_pkg::PosW'($urandom_range(1, stored_words + 1));
      end else if (op == pls_pkg::KIND_DEL_AT) begin
        pos = pls_pkg::PosW'($urandom_range(1, (stored_words == 0) ? 1 : stored_words));
      end
    end
    send_item(op, pick_word(), pos);
  endtask

  task automatic run_random(int count);
    int bias;
    int run_len;
    while (count > 0) begin
      bias    = $urandom_range(0, 2);
      run_len = $urandom_range(8, 30);
      for (int i = 0; i < run_len && count > 0; i++) begin
        send_random(bias);
        count--;
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    kind       = pls_pkg::KIND_NOP;
    value      = '0;
    position   = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 38;
    recv_idle_pct = 56;
    // empty store: dump and every delete
    send_item(pls_pkg::KIND_DUMP, 0, 0);
    send_item(pls_pkg::KIND_DEL_FIRST, 0, 0);
    send_item(pls_pkg::KIND_DEL_LAST, 0, 31);
    send_item(pls_pkg::KIND_DEL_AT, 0, 31);
    // bad insert positions, then each insert kind with extreme words
    send_item(pls_pkg::KIND_INS_AT, 5, 0);
    send_item(pls_pkg::KIND_INS_AT, 5, 2);
    send_item(pls_pkg::KIND_INS_AT, 32'sh8000_0000, 1);
    send_item(pls_pkg::KIND_INS_FIRST, 32'sh7fff_ffff, 0);
    send_item(pls_pkg::KIND_INS_LAST, -1, 31);
    send_item(pls_pkg::KIND_INS_AT, 0, 2);
    send_item(pls_pkg::KIND_INS_AT, 32'sh5555_5555, 5);
    send_item(pls_pkg::KIND_INS_AT, 32'shaaaa_aaaa, 31);
    send_item(pls_pkg::KIND_DUMP, 0, 0);
    send_item(pls_pkg::KIND_DEL_AT, 0, 0);
    send_item(pls_pkg::KIND_DEL_AT, 0, 6);
    send_item(pls_pkg::KIND_NOP, 32'sh1234_5678, 3);
    send_item(pls_pkg::KIND_DEL_AT, 0, 3);
    send_item(pls_pkg::KIND_DEL_FIRST, 0, 0);
    send_item(pls_pkg::KIND_DEL_LAST, 0, 0);
    send_item(pls_pkg::KIND_DUMP, 0, 0);
    run_random(130);

    send_idle_pct = 56;
    recv_idle_pct = 38;
    run_random(135);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(135);
    item_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("covered %0d items (%0d dumps), %0d results compared",
             items_sent, dumps_sent, compared);
    $display("idle mixes: sender-heavy receiver stalls, the reverse, and none");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
